// File: design/mwah_pkg.sv
`default_nettype none
package mwah_pkg;

  localparam int BYTE_W         = 8;
  localparam int SAMPLE_W       = 13;
  localparam int MEAN_W         = 17;
  localparam int HEAD_W         = 15;
  localparam int IN_DATA_W      = 6 * BYTE_W;
  localparam int IN_USER_W      = 1;
  localparam int OUT_FIELDS_W   = 3 * MEAN_W + HEAD_W;
  localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int DEFAULT_WINDOW = 8;

  localparam int CORDIC_STEPS   = 16;
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  localparam int XW             = 34;
  localparam int ZW             = 20;
  localparam int NORM_BIT       = 29;
  localparam int COARSE_BIT     = 25;
  localparam int HALF_PI_Q12    = 6434;
  localparam int PI_Q12         = 12868;

  localparam logic [BYTE_W-1:0] LOW_MASK = 8'b11111000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SUPD,
    T_MUL,
    T_MST,
    T_HEAD,
    T_HOLD
  } top_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_NORM,
    H_ITER,
    H_ROUND
  } head_state_t;

  // The raw word has its three low bits cleared before the shift, so the divide by 8 is exact.
  function automatic logic signed [SAMPLE_W-1:0] decode_axis(
    input logic [BYTE_W-1:0] lo,
    input logic [BYTE_W-1:0] hi
  );
    logic [BYTE_W-1:0] lm;
    lm = lo & LOW_MASK;
    return {hi, lm[BYTE_W-1:3]};
  endfunction

  function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [15:0] t;
    case (i)
      4'd0:    t = 16'd51472;
      4'd1:    t = 16'd30386;
      4'd2:    t = 16'd16055;
      4'd3:    t = 16'd8150;
      4'd4:    t = 16'd4091;
      4'd5:    t = 16'd2047;
      4'd6:    t = 16'd1024;
      4'd7:    t = 16'd512;
      4'd8:    t = 16'd256;
      4'd9:    t = 16'd128;
      4'd10:   t = 16'd64;
      4'd11:   t = 16'd32;
      4'd12:   t = 16'd16;
      4'd13:   t = 16'd8;
      4'd14:   t = 16'd4;
      default: t = 16'd2;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: design/mwah_window.sv
`default_nettype none
module mwah_window #(
  parameter int WINDOW = mwah_pkg::DEFAULT_WINDOW,
  parameter int SW     = mwah_pkg::SAMPLE_W + $clog2(mwah_pkg::DEFAULT_WINDOW)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic signed [mwah_pkg::SAMPLE_W-1:0] smp_x,
  input  wire logic signed [mwah_pkg::SAMPLE_W-1:0] smp_y,
  input  wire logic signed [mwah_pkg::SAMPLE_W-1:0] smp_z,
  output logic signed [SW-1:0]                      sum_x,
  output logic signed [SW-1:0]                      sum_y,
  output logic signed [SW-1:0]                      sum_z
);
  import mwah_pkg::*;

  localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RW  = 3 * SAMPLE_W;

  logic [RW-1:0]       mem [WINDOW];
  logic [WINDOW-1:0]   valid;
  logic [SLW-1:0]      slot;
  logic [RW-1:0]       rd_q;
  logic                rd_v;
  logic signed [SAMPLE_W-1:0] old_x, old_y, old_z;

  // Entries never written read as zero.
  always_comb begin
    old_x = rd_v ? rd_q[SAMPLE_W-1:0]            : '0;
    old_y = rd_v ? rd_q[2*SAMPLE_W-1:SAMPLE_W]   : '0;
    old_z = rd_v ? rd_q[3*SAMPLE_W-1:2*SAMPLE_W] : '0;
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[slot];
    if (wr_en) begin
      mem[slot] <= {smp_z, smp_y, smp_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_v  <= 1'b0;
      slot  <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end else begin
      rd_v <= valid[slot];
      if (wr_en) begin
        valid[slot] <= 1'b1;
        sum_x <= sum_x + SW'(smp_x) - SW'(old_x);
        sum_y <= sum_y + SW'(smp_y) - SW'(old_y);
        sum_z <= sum_z + SW'(smp_z) - SW'(old_z);
        if (slot == SLW'(WINDOW - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/mwah_heading.sv
`default_nettype none
module mwah_heading #(
  parameter int SW = mwah_pkg::SAMPLE_W + $clog2(mwah_pkg::DEFAULT_WINDOW)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [SW-1:0]               sum_x,
  input  wire logic signed [SW-1:0]               sum_y,
  output logic                                    done,
  output logic signed [mwah_pkg::HEAD_W-1:0]      heading
);
  import mwah_pkg::*;

  head_state_t             hstate, hstate_next;
  logic signed [XW-1:0]    x, y;
  logic signed [ZW-1:0]    z;
  logic [STEP_W-1:0]       i;
  logic                    sx_neg, sy_neg;

  logic signed [XW-1:0]    ext_x, ext_y, mx, dx, dy;
  logic signed [ZW-1:0]    tz, zr, a;
  logic                    norm_done, coarse, zero_vec;

  always_comb begin
    ext_x     = XW'(sum_x);
    ext_y     = XW'(sum_y);
    zero_vec  = (sum_x == '0) && (sum_y == '0);
    mx        = (x > y) ? x : y;
    norm_done = (mx >= (XW'(1) <<< NORM_BIT));
    coarse    = (mx < (XW'(1) <<< COARSE_BIT));
    dx        = y >>> i;
    dy        = x >>> i;
    tz        = ZW'(atan_q16(i));
    zr        = (z + ZW'(8)) >>> 4;
    a         = zr;
    if (a < 0) begin
      a = '0;
    end
    if (a > ZW'(HALF_PI_Q12)) begin
      a = ZW'(HALF_PI_Q12);
    end
    if (sx_neg) begin
      a = ZW'(PI_Q12) - a;
    end
    if (sy_neg) begin
      a = -a;
    end
  end

  always_comb begin
    hstate_next = hstate;
    case (hstate)
      H_IDLE: begin
        if (start && !zero_vec) begin
          hstate_next = H_NORM;
        end
      end
      H_NORM: begin
        if (norm_done) begin
          hstate_next = H_ITER;
        end
      end
      H_ITER: begin
        if (i == STEP_W'(CORDIC_STEPS - 1)) begin
          hstate_next = H_ROUND;
        end
      end
      H_ROUND: hstate_next = H_IDLE;
      default: hstate_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      done   <= 1'b0;
    end else begin
      hstate <= hstate_next;
      done   <= ((hstate == H_IDLE) && start && zero_vec) || (hstate == H_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (hstate)
      H_IDLE: begin
        x      <= sum_x[SW-1] ? -ext_x : ext_x;
        y      <= sum_y[SW-1] ? -ext_y : ext_y;
        sx_neg <= sum_x[SW-1];
        sy_neg <= sum_y[SW-1];
        z      <= '0;
        i      <= '0;
        if (start && zero_vec) begin
          heading <= '0;
        end
      end
      H_NORM: begin
        if (!norm_done) begin
          if (coarse) begin
            x <= x <<< 4;
            y <= y <<< 4;
          end else begin
            x <= x <<< 1;
            y <= y <<< 1;
          end
        end
      end
      H_ITER: begin
        if (!y[XW-1]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + tz;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - tz;
        end
        i <= i + 1'b1;
      end
      H_ROUND: heading <= a[HEAD_W-1:0];
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/magnetometer_window_average_heading.sv
// On a sample transfer the window and sums update in the cycle after acceptance.
// A report computes the three means in turn over one shared multiplier, then the heading
// unit normalizes, runs 16 CORDIC steps and rounds; the result register then loads,
// with a zero heading and no CORDIC run when the x and y sums are both zero.
// The result register holds a report while the next sample is accepted.
// Synchronous active-high reset clears the window valid bits, sums, write slot and result valid.
`default_nettype none
module magnetometer_window_average_heading #(
  parameter int WINDOW = mwah_pkg::DEFAULT_WINDOW
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high
  input  wire logic [mwah_pkg::IN_DATA_W-1:0]     s_tdata,
  // command
  input  wire logic [mwah_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // mean_x, mean_y, mean_z, heading, zero fill
  output logic [mwah_pkg::OUT_DATA_W-1:0]         m_tdata
);
  import mwah_pkg::*;

  localparam int SW  = SAMPLE_W + $clog2(WINDOW);
  localparam int N   = SW + 4;
  localparam int K   = N + $clog2(WINDOW);
  localparam int MW  = K + 1;
  localparam int PW  = N + MW;
  localparam int QW  = MEAN_W + 1;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + WINDOW - 1) / WINDOW);

  top_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] smp_x, smp_y, smp_z;
  logic signed [SW-1:0]       sum_x, sum_y, sum_z, sel;
  logic [1:0]                 ax;
  logic [SW-1:0]              mag;
  logic [N-1:0]               mag16;
  logic [PW-1:0]              prod;
  logic                       prod_neg;
  logic [QW-1:0]              q, mval;
  logic [MEAN_W-1:0]          mean_x, mean_y, mean_z;
  logic                       accept, wr_en, head_start, head_done, load;
  logic signed [HEAD_W-1:0]   heading;

  assign accept     = s_tvalid && s_tready;
  assign wr_en      = (state == T_SUPD);
  assign head_start = (state == T_MST) && (ax == 2'd2);
  assign load       = (state == T_HOLD) && (!m_tvalid || m_tready);

  mwah_window #(.WINDOW(WINDOW), .SW(SW)) u_window (
    .clk   (clk),
    .rst   (rst),
    .wr_en (wr_en),
    .smp_x (smp_x),
    .smp_y (smp_y),
    .smp_z (smp_z),
    .sum_x (sum_x),
    .sum_y (sum_y),
    .sum_z (sum_z)
  );

  mwah_heading #(.SW(SW)) u_heading (
    .clk     (clk),
    .rst     (rst),
    .start   (head_start),
    .sum_x   (sum_x),
    .sum_y   (sum_y),
    .done    (head_done),
    .heading (heading)
  );

  always_comb begin
    case (ax)
      2'd0:    sel = sum_x;
      2'd1:    sel = sum_y;
      default: sel = sum_z;
    endcase
    mag   = sel[SW-1] ? SW'(-sel) : SW'(sel);
    mag16 = {mag, 4'b0000};
    q     = prod[K +: QW];
    mval  = prod_neg ? -q : q;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      T_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (s_tuser[0] == CMD_REPORT) ? T_MUL : T_SUPD;
        end
      end
      T_SUPD: state_next = T_IDLE;
      T_MUL:  state_next = T_MST;
      T_MST:  state_next = (ax == 2'd2) ? T_HEAD : T_MUL;
      T_HEAD: begin
        if (head_done) begin
          state_next = T_HOLD;
        end
      end
      T_HOLD: begin
        if (!m_tvalid || m_tready) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      ax       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        ax <= '0;
      end else if (state == T_MST) begin
        ax <= ax + 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_x <= decode_axis(s_tdata[7:0],   s_tdata[15:8]);
      smp_y <= decode_axis(s_tdata[23:16], s_tdata[31:24]);
      smp_z <= decode_axis(s_tdata[39:32], s_tdata[47:40]);
    end
    if (state == T_MUL) begin
      prod     <= PW'(mag16) * PW'(RECIP);
      prod_neg <= sel[SW-1];
    end
    if (state == T_MST) begin
      case (ax)
        2'd0:    mean_x <= mval[MEAN_W-1:0];
        2'd1:    mean_y <= mval[MEAN_W-1:0];
        default: mean_z <= mval[MEAN_W-1:0];
      endcase
    end
    if (load) begin
      m_tdata <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, heading, mean_z, mean_y, mean_x};
    end
  end

endmodule
`default_nettype wire

// File: design/mwah_checker.sv
`default_nettype none
module mwah_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [mwah_pkg::IN_DATA_W-1:0] s_tdata,
  input wire logic [mwah_pkg::IN_USER_W-1:0] s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [mwah_pkg::OUT_DATA_W-1:0] m_tdata
);
  import mwah_pkg::*;

  localparam int HL = 3 * MEAN_W;

  logic signed [HEAD_W-1:0] head_f;
  assign head_f = m_tdata[HL +: HEAD_W];

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transfer dropped before it was taken");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("stalled result changed");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (head_f >= -HEAD_W'(PI_Q12)) && (head_f <= HEAD_W'(PI_Q12)))
    else $error("heading out of range");

  a_sample_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == CMD_SAMPLE) && !m_tvalid |=> !m_tvalid)
    else $error("sample transfer produced a result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind magnetometer_window_average_heading mwah_checker u_mwah_checker (.*);
`default_nettype wire
